// File: hdl/dtlb_pkg.sv
`default_nettype none
package dtlb_pkg;

	localparam int TLB_ENTRIES = 64;
	// cell ids cover any entry count up to 256
	localparam int CELL_ID_W = 8;
	localparam int VA_W = 64;
	localparam int PA_W = 41;
	localparam int CTX_W = 13;
	localparam int PAGE_LSB = 13;
	localparam int IDX_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_XLATE = 1'b1;

	localparam logic [1:0] FK_NONE = 2'd0;
	localparam logic [1:0] FK_PROT = 2'd1;
	localparam logic [1:0] FK_MISS = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MMU_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_CTX = 2'd1;

	localparam logic [63:0] MASK_8K = 64'hffff_ffff_ffff_e000;
	localparam logic [63:0] MASK_64K = 64'hffff_ffff_ffff_0000;
	localparam logic [63:0] MASK_512K = 64'hffff_ffff_fff8_0000;
	localparam logic [63:0] MASK_4M = 64'hffff_ffff_ffc0_0000;

	// broadcast entry write
	typedef struct packed {
		logic vld;
		logic [CELL_ID_W-1:0] idx;
		logic [VA_W-1:0] tag;
		logic [63:0] tte;
	} dtlb_wr_t;

	// lookup word handed from cell to cell
	typedef struct packed {
		logic [VA_W-1:0] va;
		logic [CTX_W-1:0] ctx;
		logic wr;
		logic usr;
		logic hit;
		logic prot;
		logic cw;
		logic [PA_W-1:0] pa;
	} dtlb_lkp_t;

	function automatic logic [63:0] page_mask(input logic [1:0] sz);
		logic [63:0] m;
		case (sz)
			2'd0: m = MASK_8K;
			2'd1: m = MASK_64K;
			2'd2: m = MASK_512K;
			default: m = MASK_4M;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// File: hdl/dtlb_req_if.sv
`default_nettype none
interface dtlb_req_if;
	import dtlb_pkg::*;

	logic valid;
	logic ready;
	logic mode;
	logic [VA_W-1:0] virtual_address;
	logic is_write;
	logic is_user;
	logic [IDX_W-1:0] entry_index;
	logic [63:0] entry_tag;
	logic [63:0] entry_tte;

	modport source (
		output valid, mode, virtual_address, is_write, is_user, entry_index,
			entry_tag, entry_tte,
		input ready
	);
	modport sink (
		input valid, mode, virtual_address, is_write, is_user, entry_index,
			entry_tag, entry_tte,
		output ready
	);
endinterface
`default_nettype wire

// File: hdl/dtlb_rsp_if.sv
`default_nettype none
interface dtlb_rsp_if;
	import dtlb_pkg::*;

	logic valid;
	logic ready;
	logic [PA_W-1:0] physical_address;
	logic can_write;
	logic [1:0] fault_kind;
	logic [3:0] fault_status;
	logic [63:0] fault_address;
	logic [63:0] tag_access;

	modport source (
		output valid, physical_address, can_write, fault_kind, fault_status,
			fault_address, tag_access,
		input ready
	);
	modport sink (
		input valid, physical_address, can_write, fault_kind, fault_status,
			fault_address, tag_access,
		output ready
	);
endinterface
`default_nettype wire

// File: hdl/dtlb_cfg_if.sv
`default_nettype none
interface dtlb_cfg_if;
	import dtlb_pkg::*;

	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/data_tlb_translate.sv
`default_nettype none
// Fully associative data TLB. A request word either writes one entry (mode 0)
// or translates an address (mode 1). Entry writes and translations with the
// MMU off give their response word in the cycle after acceptance. A translation
// with the MMU on walks a chain of TLB_ENTRIES cells, one entry per cell and
// one cell per cycle, and is held while the finished word waits for the
// output register; the response is registered after the last cell.
// One request is in the chain at a time, and a new request is taken once the
// chain is empty and the output register is free or being drained. Lower
// entries have priority on multiple hits. A protection fault updates fault
// status and fault address, a miss updates tag access; every response word
// shows these registers as they stand after its request. The configuration
// port is always ready; index 0 is mmu_enable, index 1 is primary_context,
// other indexes are ignored. No clearing pass is needed after reset.
module data_tlb_translate (
	input wire logic clk,
	input wire logic arst_n,
	dtlb_req_if.sink req,
	dtlb_rsp_if.source rsp,
	dtlb_cfg_if.sink cfg
);
	import dtlb_pkg::*;

	// configuration
	logic mmu_en_q;
	logic [CTX_W-1:0] pctx_q;

	// control
	logic busy_q;
	logic out_vld_q;

	// architectural fault registers
	logic [3:0] fsr_q;
	logic [63:0] far_q;
	logic [63:0] tag_acc_q;

	// output word
	logic [PA_W-1:0] pa_q;
	logic cw_q;
	logic [1:0] kind_q;

	logic [TLB_ENTRIES:0] vld_c;
	dtlb_lkp_t lkp_c [TLB_ENTRIES+1];

	logic accept;
	logic direct;
	logic tail_vld;
	logic fin;
	logic en;
	dtlb_wr_t wr;
	dtlb_lkp_t tail;

	// chain empty and output side able to take a word
	assign req.ready = !busy_q && (!out_vld_q || rsp.ready);
	assign accept = req.valid && req.ready;
	// entry writes and pass-through bypass the chain
	assign direct = (req.mode == MODE_WRITE) || !mmu_en_q;

	assign tail_vld = vld_c[TLB_ENTRIES];
	assign tail = lkp_c[TLB_ENTRIES];
	assign fin = tail_vld && (!out_vld_q || rsp.ready);
	// hold the chain while the finished word waits for the output register
	assign en = !(tail_vld && !fin);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mmu_en_q <= 1'b0;
			pctx_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MMU_ENABLE: mmu_en_q <= cfg.data[0];
				CFG_PRIMARY_CTX: pctx_q <= cfg.data[CTX_W-1:0];
				default: ;
			endcase
		end
	end

	// entry write, broadcast to all cells; slots past the end match no cell
	always_comb begin
		wr.vld = accept && (req.mode == MODE_WRITE);
		wr.idx = CELL_ID_W'(req.entry_index);
		wr.tag = req.entry_tag;
		wr.tte = req.entry_tte;
	end

	// head of the chain
	assign vld_c[0] = accept && !direct;
	always_comb begin
		lkp_c[0].va = req.virtual_address;
		lkp_c[0].ctx = pctx_q;
		lkp_c[0].wr = req.is_write;
		lkp_c[0].usr = req.is_user;
		lkp_c[0].hit = 1'b0;
		lkp_c[0].prot = 1'b0;
		lkp_c[0].cw = 1'b0;
		lkp_c[0].pa = '0;
	end

	for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
		dtlb_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.cell_id(CELL_ID_W'(i)),
			.wr(wr),
			.vld_in(vld_c[i]),
			.lkp_in(lkp_c[i]),
			.vld_out(vld_c[i+1]),
			.lkp_out(lkp_c[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_vld_q <= 1'b0;
			fsr_q <= '0;
			far_q <= '0;
			tag_acc_q <= '0;
		end else begin
			if (accept && !direct) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end

			if ((accept && direct) || fin) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			if (fin && tail.hit && tail.prot) begin
				// user, write, overflow if already set, valid
				fsr_q <= {tail.usr, tail.wr, (fsr_q != 4'd0), 1'b1};
				far_q <= tail.va;
			end
			if (fin && !tail.hit) begin
				tag_acc_q <= {tail.va[VA_W-1:CTX_W], tail.ctx};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && direct) begin
			if (req.mode == MODE_WRITE) begin
				pa_q <= '0;
				cw_q <= 1'b0;
			end else begin
				// mmu off: truncated pass-through
				pa_q <= req.virtual_address[PA_W-1:0];
				cw_q <= 1'b1;
			end
			kind_q <= FK_NONE;
		end else if (fin) begin
			pa_q <= tail.pa;
			cw_q <= tail.cw;
			if (!tail.hit) begin
				kind_q <= FK_MISS;
			end else if (tail.prot) begin
				kind_q <= FK_PROT;
			end else begin
				kind_q <= FK_NONE;
			end
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.physical_address = pa_q;
	assign rsp.can_write = cw_q;
	assign rsp.fault_kind = kind_q;
	assign rsp.fault_status = fsr_q;
	assign rsp.fault_address = far_q;
	assign rsp.tag_access = tag_acc_q;

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail_vld |-> busy_q)
		else $error("lookup word in chain without busy");

	a_one_in_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_c) <= 1)
		else $error("more than one lookup word in chain");

	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> (rsp.valid && !busy_q))
		else $error("finished lookup not presented");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.fault_kind == FK_NONE || rsp.fault_kind == FK_PROT
			|| rsp.fault_kind == FK_MISS))
		else $error("bad fault kind");

	a_prot_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.fault_kind != FK_NONE) |->
			(rsp.physical_address == '0 && !rsp.can_write))
		else $error("faulting word carries a translation");

endmodule
`default_nettype wire

// File: hdl/dtlb_cell.sv
`default_nettype none
module dtlb_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic [dtlb_pkg::CELL_ID_W-1:0] cell_id,
	input wire dtlb_pkg::dtlb_wr_t wr,
	input wire logic vld_in,
	input wire dtlb_pkg::dtlb_lkp_t lkp_in,
	output logic vld_out,
	output dtlb_pkg::dtlb_lkp_t lkp_out
);
	import dtlb_pkg::*;

	logic ent_vld_q;
	logic [VA_W-1:0] tag_q;
	logic [1:0] size_q;
	logic [PA_W-1:PAGE_LSB] ppn_q;
	logic priv_q;
	logic wrt_q;

	logic sel;
	logic [63:0] m;
	logic hit_here;
	logic prot;
	logic [63:0] pa64;
	dtlb_lkp_t nxt;

	assign sel = wr.vld && (wr.idx == cell_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= 1'b0;
		end else if (sel) begin
			ent_vld_q <= wr.tte[63];
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			tag_q <= wr.tag;
			size_q <= wr.tte[62:61];
			ppn_q <= wr.tte[PA_W-1:PAGE_LSB];
			priv_q <= wr.tte[2];
			wrt_q <= wr.tte[1];
		end
	end

	always_comb begin
		m = page_mask(size_q);
		hit_here = ent_vld_q && (tag_q[CTX_W-1:0] == lkp_in.ctx)
			&& ((lkp_in.va & m) == (tag_q & m));
		prot = (priv_q && lkp_in.usr) || (!wrt_q && lkp_in.wr);
		pa64 = ({{(64-PA_W){1'b0}}, ppn_q, {PAGE_LSB{1'b0}}} & m) | (lkp_in.va & ~m);
		nxt = lkp_in;
		// first hit down the chain wins
		if (!lkp_in.hit && hit_here) begin
			nxt.hit = 1'b1;
			nxt.prot = prot;
			if (!prot) begin
				nxt.pa = {pa64[PA_W-1:PAGE_LSB], {PAGE_LSB{1'b0}}};
				nxt.cw = wrt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lkp_out <= nxt;
		end
	end

endmodule
`default_nettype wire

// File: dv/data_tlb_translate_test.sv
module data_tlb_translate_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dtlb_pkg::*;

	// register index that decodes to nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	// generous bound, slowest correct run is far below this
	localparam int CYCLE_LIMIT = 1_000_000;
	// chain of TLB_ENTRIES cells plus the output register, with margin
	localparam int DRAIN_CYCLES = TLB_ENTRIES + 40;
	localparam int PHASE_COUNT = 9;
	localparam int PHASE_ITEMS = 120;
	// receiver blackout, starts once this many responses are in
	localparam int HOLD_AFTER = 440;
	localparam int HOLD_CYCLES = 600;

	// one request word as the driver presents it
	typedef struct packed {
		logic mode;
		logic [VA_W-1:0] va;
		logic wr;
		logic usr;
		logic [IDX_W-1:0] idx;
		logic [63:0] tag;
		logic [63:0] tte;
	} req_word_t;

	// one response word
	typedef struct packed {
		logic [PA_W-1:0] pa;
		logic cw;
		logic [1:0] kind;
		logic [3:0] fsr;
		logic [63:0] far;
		logic [63:0] tacc;
	} rsp_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// testbench side of every channel, known from time zero
	logic req_valid = 1'b0;
	req_word_t drive_word = '0;
	logic rsp_ready = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	dtlb_req_if req_ch ();
	dtlb_rsp_if rsp_ch ();
	dtlb_cfg_if cfg_ch ();

	assign req_ch.valid = req_valid;
	assign req_ch.mode = drive_word.mode;
	assign req_ch.virtual_address = drive_word.va;
	assign req_ch.is_write = drive_word.wr;
	assign req_ch.is_user = drive_word.usr;
	assign req_ch.entry_index = drive_word.idx;
	assign req_ch.entry_tag = drive_word.tag;
	assign req_ch.entry_tte = drive_word.tte;
	assign rsp_ch.ready = rsp_ready;
	assign cfg_ch.valid = cfg_valid;
	assign cfg_ch.index = cfg_index;
	assign cfg_ch.data = cfg_data;

	data_tlb_translate uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// page masks by tte size field, 8K 64K 512K 4M
	logic [63:0] size_mask [4] = '{MASK_8K, MASK_64K, MASK_512K, MASK_4M};

	// shadow of the TLB array, fault registers and configuration
	logic [63:0] shadow_tte [TLB_ENTRIES] = '{default: '0};
	logic [63:0] shadow_tag [TLB_ENTRIES] = '{default: '0};
	logic [3:0] shadow_fsr = '0;
	logic [63:0] shadow_far = '0;
	logic [63:0] shadow_tag_access = '0;
	logic shadow_mmu_on = 1'b0;
	logic [CTX_W-1:0] shadow_ctx = '0;

	// what the stimulus side remembers of the entries it wrote
	logic [63:0] written_tte [TLB_ENTRIES] = '{default: '0};
	logic [63:0] written_tag [TLB_ENTRIES] = '{default: '0};
	logic [CTX_W-1:0] stim_ctx = '0;

	req_word_t requests_queued [$];
	rsp_word_t translations_due [$];

	int items_sent = 0;
	int results_seen = 0;
	int fail_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 15;
	int recv_idle_pct = 63;

	// apply one request to the shadow state, return the response word it gives
	function automatic rsp_word_t tlb_translate(input req_word_t w);
		rsp_word_t r;
		logic found;
		logic [63:0] m;
		logic [63:0] phys;
		int k;
		r = '0;
		found = 1'b0;
		if (w.mode == MODE_WRITE) begin
			// every 6-bit index is a real slot with 64 entries
			shadow_tag[w.idx] = w.tag;
			shadow_tte[w.idx] = w.tte;
		end else if (!shadow_mmu_on) begin
			// pass-through, low 41 bits, always writable
			r.pa = w.va[PA_W-1:0];
			r.cw = 1'b1;
		end else begin
			// lowest matching slot wins
			for (k = 0; k < TLB_ENTRIES && !found; k++) begin
				m = size_mask[shadow_tte[k][62:61]];
				if (shadow_tte[k][63] && shadow_tag[k][CTX_W-1:0] == shadow_ctx &&
						(w.va & m) == (shadow_tag[k] & m)) begin
					found = 1'b1;
					if ((shadow_tte[k][2] && w.usr) || (!shadow_tte[k][1] && w.wr)) begin
						// protection fault: user, write, overflow, valid
						shadow_fsr = {w.usr, w.wr, shadow_fsr != 4'd0, 1'b1};
						shadow_far = w.va;
						r.kind = FK_PROT;
					end else begin
						phys = (shadow_tte[k] & m) | (w.va & ~m);
						r.pa = {phys[PA_W-1:PAGE_LSB], {PAGE_LSB{1'b0}}};
						r.cw = shadow_tte[k][1];
					end
				end
			end
			if (!found) begin
				// miss: page bits of the address with the current context below
				shadow_tag_access = {w.va[VA_W-1:CTX_W], shadow_ctx};
				r.kind = FK_MISS;
			end
		end
		r.fsr = shadow_fsr;
		r.far = shadow_far;
		r.tacc = shadow_tag_access;
		return r;
	endfunction

	// request driver: pops the next word when the channel is free, with random idle gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ch.ready)
				translations_due.push_back(tlb_translate(drive_word));
			if (!req_valid || req_ch.ready) begin
				if (requests_queued.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					drive_word <= requests_queued.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response ready, with one long blackout so the chain backs up
	int hold_left = 0;
	logic hold_done = 1'b0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				rsp_ready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// register writes reach the shadow configuration
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ch.ready) begin
			case (cfg_index)
				CFG_MMU_ENABLE: shadow_mmu_on = cfg_data[0];
				CFG_PRIMARY_CTX: shadow_ctx = cfg_data[CTX_W-1:0];
				default: ;
			endcase
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	// response monitor, each word against the oldest one due
	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ready) begin
			results_seen++;
			if (translations_due.size() == 0) begin
				fail_count++;
				$display("%0t: response word with none due, expected nothing, got pa %h kind %0d",
					$time, rsp_ch.physical_address, rsp_ch.fault_kind);
			end else begin
				want = translations_due.pop_front();
				check_field("physical_address", 64'(want.pa), 64'(rsp_ch.physical_address));
				check_field("can_write", 64'(want.cw), 64'(rsp_ch.can_write));
				check_field("fault_kind", 64'(want.kind), 64'(rsp_ch.fault_kind));
				check_field("fault_status", 64'(want.fsr), 64'(rsp_ch.fault_status));
				check_field("fault_address", want.far, rsp_ch.fault_address);
				check_field("tag_access", want.tacc, rsp_ch.tag_access);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("data_tlb_translate test failed");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// random translation word with the fields that matter forced
	function automatic logic [63:0] make_tte(input logic valid, input logic [1:0] size,
			input logic priv, input logic writable);
		logic [63:0] t;
		t = rand64();
		t[63] = valid;
		t[62:61] = size;
		t[2] = priv;
		t[1] = writable;
		return t;
	endfunction

	// entry write word, unused fields random
	function automatic req_word_t entry_write(input logic [IDX_W-1:0] idx,
			input logic [63:0] tag, input logic [63:0] tte);
		req_word_t w;
		w.mode = MODE_WRITE;
		w.va = rand64();
		w.wr = 1'($urandom_range(1));
		w.usr = 1'($urandom_range(1));
		w.idx = idx;
		w.tag = tag;
		w.tte = tte;
		return w;
	endfunction

	// translate word, unused fields random
	function automatic req_word_t lookup_word(input logic [63:0] va, input logic wr,
			input logic usr);
		req_word_t w;
		w.mode = MODE_XLATE;
		w.va = va;
		w.wr = wr;
		w.usr = usr;
		w.idx = IDX_W'($urandom_range(TLB_ENTRIES - 1));
		w.tag = rand64();
		w.tte = rand64();
		return w;
	endfunction

	task automatic send(input req_word_t w);
		if (w.mode == MODE_WRITE) begin
			written_tag[w.idx] = w.tag;
			written_tte[w.idx] = w.tte;
		end
		requests_queued.push_back(w);
		items_sent++;
	endtask

	// hold off until every word sent has its response
	task automatic settle();
		while (results_seen < items_sent)
			@(posedge clk);
	endtask

	// register write, only once the block has gone quiet
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		settle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_PRIMARY_CTX)
			stim_ctx = val[CTX_W-1:0];
	endtask

	// mostly well-formed traffic: entries in the live context and lookups aimed at them
	task automatic random_phase(input int count);
		int i;
		int tries;
		int pick;
		int slot;
		logic [63:0] m;
		logic [CTX_W-1:0] ctx;
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				ctx = ($urandom_range(9) < 7) ? stim_ctx : CTX_W'($urandom_range(8191));
				send(entry_write(IDX_W'($urandom_range(TLB_ENTRIES - 1)),
					{rand64() >> CTX_W << CTX_W} | 64'(ctx),
					make_tte($urandom_range(99) < 85, 2'($urandom_range(3)),
						$urandom_range(99) < 30, $urandom_range(99) < 60)));
			end else if (pick < 80) begin
				// aim at a live slot if one turns up within a few tries
				slot = $urandom_range(TLB_ENTRIES - 1);
				for (tries = 0; tries < 8; tries++) begin
					if (written_tte[slot][63] && written_tag[slot][CTX_W-1:0] == stim_ctx)
						break;
					slot = $urandom_range(TLB_ENTRIES - 1);
				end
				m = size_mask[written_tte[slot][62:61]];
				send(lookup_word((written_tag[slot] & m) | (rand64() & ~m),
					1'($urandom_range(1)), 1'($urandom_range(1))));
			end else begin
				// stray address, nearly always a miss
				send(lookup_word(rand64(), 1'($urandom_range(1)), 1'($urandom_range(1))));
			end
		end
	endtask

	// directed pages at each size boundary
	localparam logic [63:0] PAGE_8K = 64'h0000_1234_5678_a000;
	localparam logic [63:0] PAGE_64K = 64'h0000_0000_7fff_0000;
	localparam logic [63:0] PAGE_512K = 64'h8000_0000_0008_0000;
	localparam logic [63:0] PAGE_4M = 64'hffff_ffff_ffc0_0000;
	localparam logic [63:0] PAGE_DEAD = 64'h0000_0abc_de00_0000;

	initial begin
		int p;
		logic mmu_on;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// mmu off after reset: pass-through at both extremes
		send(lookup_word('1, 1'b1, 1'b1));
		send(lookup_word('0, 1'b0, 1'b0));
		// 8K page, writable, context 0
		send(entry_write(IDX_W'(0), PAGE_8K, make_tte(1'b1, 2'd0, 1'b0, 1'b1)));
		// top slot, 4M privileged read-only page in context 8191
		send(entry_write(IDX_W'(TLB_ENTRIES - 1), PAGE_4M | 64'h1fff,
			make_tte(1'b1, 2'd3, 1'b1, 1'b0)));
		// 64K privileged read-only page
		send(entry_write(IDX_W'(1), PAGE_64K, make_tte(1'b1, 2'd1, 1'b1, 1'b0)));
		// 512K page twice: slot 2 must shadow slot 5
		send(entry_write(IDX_W'(2), PAGE_512K, make_tte(1'b1, 2'd2, 1'b0, 1'b1)));
		send(entry_write(IDX_W'(5), PAGE_512K, make_tte(1'b1, 2'd2, 1'b0, 1'b0)));
		// invalid entry
		send(entry_write(IDX_W'(3), PAGE_DEAD, make_tte(1'b0, 2'd3, 1'b0, 1'b1)));

		// mmu on, enable word with every upper bit set
		write_reg(CFG_MMU_ENABLE, '1);
		write_reg(CFG_PRIMARY_CTX, '0);
		send(lookup_word(PAGE_8K | 64'h1fff, 1'b0, 1'b1));
		send(lookup_word(PAGE_8K | 64'h0123, 1'b1, 1'b0));
		send(lookup_word('1, 1'b0, 1'b0));
		// user on privileged page, then a store to read-only, which overflows
		send(lookup_word(PAGE_64K | 64'hffff, 1'b0, 1'b1));
		send(lookup_word(PAGE_64K, 1'b1, 1'b0));
		send(lookup_word(PAGE_64K | 64'h2000, 1'b0, 1'b0));
		send(lookup_word(PAGE_512K | 64'h7ffff, 1'b1, 1'b1));
		send(lookup_word(PAGE_DEAD | 64'h1000, 1'b0, 1'b0));

		// highest context
		write_reg(CFG_PRIMARY_CTX, '1);
		send(lookup_word(PAGE_4M | 64'h3fffff, 1'b0, 1'b0));
		send(lookup_word(PAGE_4M, 1'b0, 1'b1));
		send(lookup_word(PAGE_8K, 1'b0, 1'b0));
		// write to an index that decodes to nothing
		write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(8191)));
		send(lookup_word(PAGE_4M | 64'h1, 1'b1, 1'b0));

		// random phases: mmu off twice, context at both extremes then random
		for (p = 0; p < PHASE_COUNT; p++) begin
			mmu_on = (p != 2 && p != 5);
			write_reg(CFG_MMU_ENABLE, {12'($urandom_range(4095)), mmu_on});
			if (p == 0)
				write_reg(CFG_PRIMARY_CTX, '0);
			else if (p == 1)
				write_reg(CFG_PRIMARY_CTX, '1);
			else
				write_reg(CFG_PRIMARY_CTX, CTX_W'($urandom_range(8191)));
			if (p == 4)
				write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(8191)));
			// sender light and receiver heavy, then swapped, then no gaps
			if (p < 3) begin
				send_idle_pct = 15;
				recv_idle_pct = 63;
			end else if (p < 6) begin
				send_idle_pct = 63;
				recv_idle_pct = 15;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_phase(PHASE_ITEMS);
		end

		settle();
		// catch any stray word after the last one due
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (translations_due.size() != 0) begin
			fail_count++;
			$display("%0t: responses still due, expected 0, got %0d", $time,
				translations_due.size());
		end
		if (fail_count == 0)
			$display("data_tlb_translate test passed");
		else
			$display("data_tlb_translate test failed");
		$finish;
	end

endmodule
